FILE: sv/stream_rate_controller_assert.svh
// Assertion macros for the stream rate controller checker.
`ifndef STREAM_RATE_CONTROLLER_ASSERT_SVH
`define STREAM_RATE_CONTROLLER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SRC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("stream_rate_controller: check failed");

// Next-cycle implication.
`define SRC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("stream_rate_controller: check failed");

`endif

FILE: sv/src_pkg.sv
// Shared types, widths and constants of the stream rate controller.
`default_nettype none

package src_pkg;

   localparam int RATE_W  = 32;
   localparam int GAIN_W  = 16;
   localparam int IDX_W   = 3;
   localparam int MUL_A_W = GAIN_W;
   localparam int MUL_B_W = RATE_W + 1;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // register indexes
   localparam logic [IDX_W-1:0] REG_U_MAX           = 3'd0;
   localparam logic [IDX_W-1:0] REG_U_MIN           = 3'd1;
   localparam logic [IDX_W-1:0] REG_U_STEP          = 3'd2;
   localparam logic [IDX_W-1:0] REG_GAIN_INTEGRAL   = 3'd3;
   localparam logic [IDX_W-1:0] REG_ERROR_THRESHOLD = 3'd4;
   localparam logic [IDX_W-1:0] REG_GAIN_JITTER     = 3'd5;
   localparam logic [IDX_W-1:0] REG_GAIN_DELAY      = 3'd6;

   // reset values
   localparam logic [RATE_W-1:0] U_MAX_RESET     = 32'd65536000;
   localparam logic [RATE_W-1:0] U_MIN_RESET     = 32'd65536;
   localparam logic [RATE_W-1:0] U_STEP_RESET    = 32'd65536;
   localparam logic [RATE_W-1:0] THRESHOLD_RESET = 32'd65536;
   localparam logic [GAIN_W-1:0] GAIN_RESET      = 16'd256;

   typedef struct packed {
      logic [RATE_W-1:0] u_max;
      logic [RATE_W-1:0] u_min;
      logic [RATE_W-1:0] u_step;
      logic [GAIN_W-1:0] gain_integral;
      logic [RATE_W-1:0] error_threshold;
      logic [GAIN_W-1:0] gain_jitter;
      logic [GAIN_W-1:0] gain_delay;
   } cfg_type;

   // stored-rate reload on a u_max write
   typedef struct packed {
      logic              load;
      logic [RATE_W-1:0] value;
   } reload_type;

endpackage

`default_nettype wire

FILE: sv/src_csr.sv
// Configuration register file of the stream rate controller.
`default_nettype none

module src_csr
   import src_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_valid,
   input  wire logic [IDX_W-1:0]  csr_index,
   input  wire logic [RATE_W-1:0] csr_data,
   output cfg_type                cfg,
   output reload_type             reload
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    load_in;

   always_comb begin
      cfg_in  = cfg_ff;
      load_in = 1'b0;
      if (csr_valid) begin
         unique case (csr_index)
            REG_U_MAX: begin
               cfg_in.u_max = csr_data;
               load_in      = 1'b1;
            end
            REG_U_MIN:           cfg_in.u_min           = csr_data;
            REG_U_STEP:          cfg_in.u_step          = csr_data;
            REG_GAIN_INTEGRAL:   cfg_in.gain_integral   = csr_data[GAIN_W-1:0];
            REG_ERROR_THRESHOLD: cfg_in.error_threshold = csr_data;
            REG_GAIN_JITTER:     cfg_in.gain_jitter     = csr_data[GAIN_W-1:0];
            REG_GAIN_DELAY:      cfg_in.gain_delay      = csr_data[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.u_max           <= U_MAX_RESET;
         cfg_ff.u_min           <= U_MIN_RESET;
         cfg_ff.u_step          <= U_STEP_RESET;
         cfg_ff.gain_integral   <= GAIN_RESET;
         cfg_ff.error_threshold <= THRESHOLD_RESET;
         cfg_ff.gain_jitter     <= GAIN_RESET;
         cfg_ff.gain_delay      <= GAIN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg          = cfg_ff;
   // takes effect at the same edge as the register write
   assign reload.load  = load_in;
   assign reload.value = csr_data;

endmodule

`default_nettype wire

FILE: sv/src_mul.sv
// Shared registered multiplier: 16-bit gain by 33-bit operand.
`default_nettype none

module src_mul
   import src_pkg::*;
(
   input  wire logic               clock,
   input  wire logic [MUL_A_W-1:0] mul_a,
   input  wire logic [MUL_B_W-1:0] mul_b,
   output logic      [MUL_P_W-1:0] product
);

   logic [MUL_P_W-1:0] product_ff;
   logic [MUL_P_W-1:0] product_in;

   assign product_in = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

`default_nettype wire

FILE: sv/src_core.sv
// Sequencer and datapath: error, branch choice, rate update and result register.
`default_nettype none

module src_core
   import src_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cfg_type            cfg,
   input  wire reload_type         reload,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [RATE_W-1:0]  req_jitter_variance,
   input  wire logic [RATE_W-1:0]  req_average_delay,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic      [RATE_W-1:0]  rsp_error_value,
   output logic      [RATE_W-1:0]  rsp_rate_command,
   output logic                    rsp_decreasing,
   output logic      [MUL_A_W-1:0] mul_a,
   output logic      [MUL_B_W-1:0] mul_b,
   input  wire logic [MUL_P_W-1:0] product
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MJ   = 3'd1;  // issue gain_jitter * variance
   localparam logic [2:0] S_MD   = 3'd2;  // issue gain_delay * delay
   localparam logic [2:0] S_CMP  = 3'd3;  // sum, saturate, pick branch
   localparam logic [2:0] S_MI   = 3'd4;  // issue gain_integral * error sum
   localparam logic [2:0] S_DEC  = 3'd5;
   localparam logic [2:0] S_INC  = 3'd6;
   localparam logic [2:0] S_DONE = 3'd7;

   localparam int ACC_W = MUL_P_W;

   logic [2:0]        state_ff, state_in;
   logic [RATE_W-1:0] var_ff, dly_ff;
   logic [ACC_W-1:0]  acc_ff;
   logic [RATE_W-1:0] e_ff, e_in;
   logic              dec_ff;
   logic [RATE_W-1:0] rate_ff, rate_in;
   logic              upd_ff, upd_in;
   logic [RATE_W-1:0] prev_rate_ff, prev_error_ff;
   logic              rsp_valid_ff;
   logic [RATE_W-1:0] rsp_error_ff, rsp_rate_ff;
   logic              rsp_dec_ff;

   logic                req_acc, out_free;
   logic [ACC_W-1:0]    sum_full;
   logic [RATE_W:0]     esum;
   logic [ACC_W-10:0]   amount;
   logic [ACC_W-9:0]    diff_wide;
   logic [RATE_W:0]     inc_sum;

   assign req_stall = (state_ff != S_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // error: full sum of both products, >>8, saturated to 32 bits
   assign sum_full = acc_ff + product;
   assign e_in     = (|sum_full[ACC_W-1:RATE_W+8]) ? {RATE_W{1'b1}}
                                                   : sum_full[RATE_W+7:8];

   assign esum      = {1'b0, e_ff} + {1'b0, prev_error_ff};
   assign amount    = product[ACC_W-1:9];
   assign diff_wide = {(ACC_W-8-RATE_W)'(0), prev_rate_ff} - {1'b0, amount};
   assign inc_sum   = {1'b0, prev_rate_ff} + {1'b0, cfg.u_step};

   always_comb begin
      unique case (state_ff)
         S_MD: begin
            mul_a = cfg.gain_delay;
            mul_b = {1'b0, dly_ff};
         end
         S_MI: begin
            mul_a = cfg.gain_integral;
            mul_b = esum;
         end
         default: begin
            mul_a = cfg.gain_jitter;
            mul_b = {1'b0, var_ff};
         end
      endcase
   end

   always_comb begin
      rate_in = rate_ff;
      upd_in  = upd_ff;
      if (state_ff == S_DEC) begin
         upd_in = 1'b1;
         // borrow means the amount is larger than the stored rate
         if (diff_wide[ACC_W-9]) begin
            rate_in = cfg.u_min;
         end else if (diff_wide[RATE_W-1:0] < cfg.u_min) begin
            rate_in = cfg.u_min;
         end else begin
            rate_in = diff_wide[RATE_W-1:0];
         end
      end else if (state_ff == S_INC) begin
         if (inc_sum > {1'b0, cfg.u_max}) begin
            rate_in = cfg.u_max;
            upd_in  = 1'b0;
         end else begin
            rate_in = inc_sum[RATE_W-1:0];
            upd_in  = 1'b1;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_acc) state_in = S_MJ;
         S_MJ:   state_in = S_MD;
         S_MD:   state_in = S_CMP;
         S_CMP:  state_in = (e_in >= cfg.error_threshold) ? S_MI : S_INC;
         S_MI:   state_in = S_DEC;
         S_DEC:  state_in = S_DONE;
         S_INC:  state_in = S_DONE;
         S_DONE: if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         prev_rate_ff  <= U_MAX_RESET;
         prev_error_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
            if (upd_ff) prev_rate_ff  <= rate_ff;
            if (dec_ff) prev_error_ff <= e_ff;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (reload.load) prev_rate_ff <= reload.value;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         var_ff <= req_jitter_variance;
         dly_ff <= req_average_delay;
      end
      if (state_ff == S_MD) acc_ff <= product;
      if (state_ff == S_CMP) begin
         e_ff   <= e_in;
         dec_ff <= (e_in >= cfg.error_threshold);
      end
      rate_ff <= rate_in;
      upd_ff  <= upd_in;
      if (state_ff == S_DONE && out_free) begin
         rsp_error_ff <= e_ff;
         rsp_rate_ff  <= rate_ff;
         rsp_dec_ff   <= dec_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_error_value  = rsp_error_ff;
   assign rsp_rate_command = rsp_rate_ff;
   assign rsp_decreasing   = rsp_dec_ff;

endmodule

`default_nettype wire

FILE: sv/stream_rate_controller.sv
// Stream rate controller: top level.
// Usage:
//   req_*: one measurement (jitter variance, average delay, unsigned Q16.16)
//     per transaction; taken on a clock edge with req_valid high and
//     req_stall low. req_stall is high while a measurement is in work.
//   rsp_*: one result per measurement (error, rate command, branch flag);
//     taken on a clock edge with rsp_valid high and rsp_stall low.
//   csr_*: register writes, index 0..6, csr_ready is always high; write
//     only while idle. Writing u_max also reloads the stored rate.
// Steps: one shared 16x33 multiplier is used for the two error products
//   and, on the decrease branch, the integral product. The states issue
//   the jitter and the delay product, compare, then issue the integral
//   product and decrease, or increase; the next measurement is taken only
//   once the result of the last has moved into the output register.
// Stall: a finished result waits in the output register; the next
//   measurement is accepted meanwhile and its result is held back until
//   the output register is taken.
// Reset (synchronous): registers return to defaults, stored rate to u_max,
//   stored error to zero, no result pending.
`default_nettype none

module stream_rate_controller
   import src_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [RATE_W-1:0] req_jitter_variance,
   input  wire logic [RATE_W-1:0] req_average_delay,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic      [RATE_W-1:0] rsp_error_value,
   output logic      [RATE_W-1:0] rsp_rate_command,
   output logic                   rsp_decreasing,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [IDX_W-1:0]  csr_index,
   input  wire logic [RATE_W-1:0] csr_data
);

   cfg_type            cfg;
   reload_type         reload;
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [MUL_P_W-1:0] product;

   assign csr_ready = 1'b1;

   src_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg),
      .reload    (reload)
   );

   src_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (product)
   );

   src_core u_core (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg),
      .reload              (reload),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_jitter_variance (req_jitter_variance),
      .req_average_delay   (req_average_delay),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_error_value     (rsp_error_value),
      .rsp_rate_command    (rsp_rate_command),
      .rsp_decreasing      (rsp_decreasing),
      .mul_a               (mul_a),
      .mul_b               (mul_b),
      .product             (product)
   );

endmodule

`default_nettype wire

FILE: sv/src_checker.sv
// Port-level checker for the stream rate controller, bound to the top level.
`default_nettype none
`include "stream_rate_controller_assert.svh"

module src_checker
   import src_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire logic [RATE_W-1:0] rsp_error_value,
   input wire logic [RATE_W-1:0] rsp_rate_command,
   input wire logic              rsp_decreasing
);

   logic                req_acc;
   logic                rsp_hold;
   logic [2*RATE_W:0]   rsp_payload;

   assign req_acc     = req_valid && !req_stall;
   assign rsp_hold    = rsp_valid && rsp_stall;
   assign rsp_payload = {rsp_error_value, rsp_rate_command, rsp_decreasing};

   // busy right after taking a measurement
   `SRC_ASSERT_NEXT(a_busy_after_accept, req_acc, req_stall)
   // no result rises in the cycle after a measurement is taken
   `SRC_ASSERT_NEXT(a_no_instant_result, req_acc, !$rose(rsp_valid))
   // a new result only leaves a busy block
   `SRC_ASSERT_NOW(a_result_from_busy, $rose(rsp_valid), $past(req_stall))
   // stalled result holds
   `SRC_ASSERT_NEXT(a_rsp_hold, rsp_hold, rsp_valid && $stable(rsp_payload))

endmodule

bind stream_rate_controller src_checker u_src_checker (.*);

`default_nettype wire

FILE: dv/stream_rate_controller_test.sv
`timescale 1ns / 100ps
// Testbench for the stream rate controller: directed and random measurements vs. a predictor.
module stream_rate_controller_test
   import src_pkg::*;
();

   localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

   typedef struct packed {
      logic [RATE_W-1:0] error_value;
      logic [RATE_W-1:0] rate_command;
      logic              decreasing;
   } rate_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic [RATE_W-1:0] req_jitter_variance = '0;
   logic [RATE_W-1:0] req_average_delay = '0;
   logic              rsp_stall = 1'b0;
   logic              csr_valid = 1'b0;
   logic [IDX_W-1:0]  csr_index = '0;
   logic [RATE_W-1:0] csr_data = '0;
   logic              req_stall;
   logic              rsp_valid;
   logic [RATE_W-1:0] rsp_error_value;
   logic [RATE_W-1:0] rsp_rate_command;
   logic              rsp_decreasing;
   logic              csr_ready;

   cfg_type           ctl_regs;
   logic [RATE_W-1:0] stored_rate;
   logic [RATE_W-1:0] stored_error;
   rate_result_type   expected_q[$];

   int send_idle_pct = 0;
   int stall_pct = 0;
   int mismatches = 0;
   int items_sent = 0;
   int results_seen = 0;
   int decreases_seen = 0;

   stream_rate_controller u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_jitter_variance (req_jitter_variance),
      .req_average_delay   (req_average_delay),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_error_value     (rsp_error_value),
      .rsp_rate_command    (rsp_rate_command),
      .rsp_decreasing      (rsp_decreasing),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

   // Rate update for one measurement; advances the stored rate and error.
   function automatic rate_result_type predict_rate(input logic [RATE_W-1:0] jit,
                                                    input logic [RATE_W-1:0] dly);
      logic [63:0]     acc;
      logic [63:0]     sum;
      logic [63:0]     esum;
      logic [63:0]     amount;
      rate_result_type r;
      acc = ctl_regs.gain_jitter * jit + ctl_regs.gain_delay * dly;
      acc = acc >> 8;
      r.error_value = (acc > 64'hFFFF_FFFF) ? '1 : acc[31:0];
      if (r.error_value < ctl_regs.error_threshold) begin
         r.decreasing = 1'b0;
         sum = stored_rate + ctl_regs.u_step;
         if (sum > ctl_regs.u_max) begin
            r.rate_command = ctl_regs.u_max;
         end else begin
            r.rate_command = sum[31:0];
            stored_rate = sum[31:0];
         end
      end else begin
         r.decreasing = 1'b1;
         esum = r.error_value + stored_error;
         amount = (ctl_regs.gain_integral * esum) >> 9;
         stored_error = r.error_value;
         if (amount > stored_rate) begin
            r.rate_command = ctl_regs.u_min;
         end else begin
            sum = stored_rate - amount;
            r.rate_command = (sum[31:0] < ctl_regs.u_min) ? ctl_regs.u_min : sum[31:0];
         end
         stored_rate = r.rate_command;
      end
      return r;
   endfunction

   function automatic logic [31:0] spread32();
      if ($urandom_range(15, 0) == 0) return '1;
      return $urandom >> $urandom_range(31, 0);
   endfunction

   // gain in the low half, junk above it that the block must drop
   function automatic logic [31:0] gain_word();
      logic [31:0] w;
      w = $urandom;
      case ($urandom_range(3, 0))
         0: w[15:0] = GAIN_RESET;
         1: w[15:0] = '1;
         default: w[15:0] = w[15:0] >> $urandom_range(15, 0);
      endcase
      return w;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      if (mismatches <= 20)
         $display("mismatch: %s: got %h, want %h at %0t", what, got, want, $time);
   endtask

   // leaves csr_valid high; the next send or drain lowers it
   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_U_MAX: begin
            ctl_regs.u_max = data;
            stored_rate = data;
         end
         REG_U_MIN:           ctl_regs.u_min = data;
         REG_U_STEP:          ctl_regs.u_step = data;
         REG_GAIN_INTEGRAL:   ctl_regs.gain_integral = data[GAIN_W-1:0];
         REG_ERROR_THRESHOLD: ctl_regs.error_threshold = data;
         REG_GAIN_JITTER:     ctl_regs.gain_jitter = data[GAIN_W-1:0];
         REG_GAIN_DELAY:      ctl_regs.gain_delay = data[GAIN_W-1:0];
         default: ;
      endcase
   endtask

   // leaves req_valid high so back-to-back transactions need no gap
   task automatic send_measurement(input logic [RATE_W-1:0] jit,
                                   input logic [RATE_W-1:0] dly);
      csr_valid <= 1'b0;
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_jitter_variance <= jit;
      req_average_delay <= dly;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_q.push_back(predict_rate(jit, dly));
      items_sent++;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      csr_valid <= 1'b0;
      do @(posedge clock); while (expected_q.size() != 0);
   endtask

   always @(posedge clock) begin : check_results
      rate_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99, 0) < stall_pct);
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_q.size() == 0) begin
               report_mismatch("result with nothing expected", rsp_rate_command, '0);
            end else begin
               want = expected_q.pop_front();
               if (rsp_error_value !== want.error_value)
                  report_mismatch("error_value", rsp_error_value, want.error_value);
               if (rsp_rate_command !== want.rate_command)
                  report_mismatch("rate_command", rsp_rate_command, want.rate_command);
               if (rsp_decreasing !== want.decreasing)
                  report_mismatch("decreasing", rsp_decreasing, want.decreasing);
               if (want.decreasing) decreases_seen++;
            end
         end
      end
   end

   task automatic test_reset_values();
      send_measurement('0, '0);               // climbs past u_max, clamps
      send_measurement(32'h0001_0000, '0);    // error equal to threshold decreases
      send_measurement('0, 32'h0002_0000);    // trapezoid with previous error
      send_measurement('0, '0);               // calm step keeps stored error
      send_measurement('1, '1);               // saturated error, falls to u_min
      drain_results();
   endtask

   task automatic test_field_extremes();
      write_reg(REG_GAIN_JITTER, 32'hA5A5_FFFF);
      write_reg(REG_GAIN_DELAY, 32'h5A5A_FFFF);
      write_reg(REG_ERROR_THRESHOLD, 32'h8000_0000);
      write_reg(REG_GAIN_INTEGRAL, 32'h0000_0001);
      write_reg(REG_U_STEP, 32'h0040_0000);
      send_measurement('0, '0);
      send_measurement('1, '0);
      send_measurement('0, '1);
      send_measurement(32'h5555_5555, 32'hAAAA_AAAA);
      send_measurement(32'hAAAA_AAAA, 32'h5555_5555);
      send_measurement(32'h0000_0001, 32'h0000_0001);
      send_measurement(32'h0000_0100, '0);
      drain_results();
   endtask

   task automatic test_rate_limits();
      write_reg(REG_U_MAX, '1);
      write_reg(REG_U_STEP, '1);
      write_reg(REG_U_MIN, '0);
      write_reg(REG_ERROR_THRESHOLD, '1);
      write_reg(REG_GAIN_INTEGRAL, '0);
      write_reg(REG_GAIN_JITTER, GAIN_RESET);
      write_reg(REG_GAIN_DELAY, GAIN_RESET);
      send_measurement('0, '0);    // sum needs a 33rd bit
      send_measurement('1, '1);    // saturated error meets the top threshold
      drain_results();
      // minimum above maximum
      write_reg(REG_U_MAX, 32'h0000_0100);
      write_reg(REG_U_STEP, '0);
      write_reg(REG_U_MIN, 32'h0000_1000);
      write_reg(REG_GAIN_INTEGRAL, 32'h0000_FFFF);
      write_reg(REG_ERROR_THRESHOLD, 32'h0000_0010);
      write_reg(REG_UNUSED, '1);   // ignored
      send_measurement('0, '0);
      send_measurement('0, 32'h0001_0000);
      send_measurement('0, '0);
      send_measurement('0, '0);
      drain_results();
   endtask

   task automatic random_settings();
      logic [31:0] top;
      top = spread32();
      write_reg(REG_U_MAX, top);
      write_reg(REG_U_MIN, ($urandom_range(7, 0) == 0) ? spread32()
                                                      : top >> $urandom_range(31, 1));
      write_reg(REG_U_STEP, ($urandom_range(7, 0) == 0) ? spread32()
                                                       : top >> $urandom_range(31, 2));
      write_reg(REG_GAIN_INTEGRAL, gain_word());
      write_reg(REG_ERROR_THRESHOLD, spread32());
      write_reg(REG_GAIN_JITTER, gain_word());
      write_reg(REG_GAIN_DELAY, gain_word());
      if ($urandom_range(3, 0) == 0) write_reg(REG_UNUSED, $urandom);
   endtask

   // bursts of calm and congested measurements so the rate swings between limits
   task automatic test_random_traffic();
      int phase;
      int setting;
      int n;
      int burst;
      bit calm;
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 68; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 68; end
            default: begin send_idle_pct = 27; stall_pct = 27; end
         endcase
         for (setting = 0; setting < 3; setting++) begin
            drain_results();
            random_settings();
            n = 0;
            while (n < 120) begin
               burst = $urandom_range(16, 1);
               calm = $urandom_range(1, 0);
               repeat (burst) begin
                  if (calm)
                     send_measurement($urandom_range(255, 0), $urandom_range(255, 0));
                  else
                     send_measurement(spread32(), spread32());
                  n++;
               end
            end
         end
      end
   endtask

   initial begin
      ctl_regs.u_max = U_MAX_RESET;
      ctl_regs.u_min = U_MIN_RESET;
      ctl_regs.u_step = U_STEP_RESET;
      ctl_regs.gain_integral = GAIN_RESET;
      ctl_regs.error_threshold = THRESHOLD_RESET;
      ctl_regs.gain_jitter = GAIN_RESET;
      ctl_regs.gain_delay = GAIN_RESET;
      stored_rate = U_MAX_RESET;
      stored_error = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_field_extremes();
      test_rate_limits();
      test_random_traffic();
      drain_results();
      repeat (8) @(posedge clock);
      $display("summary: %0d measurements, %0d results checked, %0d on the decrease branch",
               items_sent, results_seen, decreases_seen);
      $display("summary: 12 random register settings over four send/stall mixes");
      if (mismatches == 0 && expected_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

FILE: stream_rate_controller.f
+incdir+sv
sv/src_pkg.sv
sv/src_csr.sv
sv/src_mul.sv
sv/src_core.sv
sv/stream_rate_controller.sv
sv/src_checker.sv
dv/stream_rate_controller_test.sv
